@@ hw/rtl/bitmap_frame_allocator_unit_defines.svh @@
// Assertion macros shared by the frame allocator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame allocator check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame allocator check failed in the following cycle");

`endif

@@ hw/rtl/bfa_pkg.sv @@
package bfa_pkg;

    // Geometry of the managed memory.
    localparam int unsigned NUM_FRAMES  = 524288;
    localparam int unsigned FRAME_BYTES = 4096;
    localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);

    // Bitmap organization: one 64-bit word per memory row.
    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned BIT_AW    = $clog2(WORD_BITS);
    localparam int unsigned WORDS     = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    // A frame index runs from 0 up to and including NUM_FRAMES.
    localparam int unsigned FRAME_AW = $clog2(NUM_FRAMES + 1);

    // Bits of the last word that lie past the end of memory read as allocated.
    localparam int unsigned LAST_BITS = NUM_FRAMES - (WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        (LAST_BITS == WORD_BITS) ? '0 : ~((64'd1 << LAST_BITS) - 64'd1);

    // Field widths.
    localparam int unsigned ADDR_W     = 52;
    localparam int unsigned END_W      = ADDR_W + 2;
    localparam int unsigned OUT_ADDR_W = 31;

    typedef enum logic [1:0] {
        FUNC_MARK_ALL = 2'd0,
        FUNC_RELEASE  = 2'd1,
        FUNC_ALLOC    = 2'd2,
        FUNC_FREE     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_OOM     = 2'd1,
        STATUS_BADFREE = 2'd2
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  region_length;
        logic               region_usable;
    } cmd_t;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] frame_address;
        status_t               status;
    } result_t;

endpackage

@@ hw/rtl/bitmap_frame_allocator_unit.sv @@
// Channel   | Ports                  | Word moved
// ----------+------------------------+-------------------------------------------
// command   | start, busy, command   | operation, address, length, usable flag
// result    | done, result           | frame address and status, one per command
//
// Mark all writes every bitmap row, one row per cycle.
// Release reads and writes each row the region touches; an unusable region ends in idle.
// Allocate scans rows from the cursor, or ends in idle with the cursor at the end.
// Free checks the frame, then reads and clears its bit; past the end it is refused.
// After reset a fill pass sets every row while busy is high.
// The single bitmap memory port pair paces these steps; done cannot be held off.
`include "bitmap_frame_allocator_unit_defines.svh"

module bitmap_frame_allocator_unit
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  bfa_pkg::cmd_t   command,
    output logic            done,
    output bfa_pkg::result_t result
);

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_REL_SUM,
        S_REL_CLIP,
        S_REL_RD,
        S_REL_WR,
        S_ALLOC_CHK,
        S_FREE_CHK,
        S_FREE_WR
    } state_t;

    localparam logic [bfa_pkg::WORD_BITS-1:0] ONES = '1;
    localparam logic [bfa_pkg::WORD_AW-1:0] LAST_WORD = bfa_pkg::WORD_AW'(bfa_pkg::WORDS - 1);
    localparam logic [bfa_pkg::FRAME_AW-1:0] END_FRAME = bfa_pkg::FRAME_AW'(bfa_pkg::NUM_FRAMES);

    // Control and payload registers.
    state_t                          state_reg, state_next;
    bfa_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [bfa_pkg::END_W-1:0]       end_reg, end_next;
    logic [bfa_pkg::FRAME_AW-1:0]    first_reg, first_next;
    logic [bfa_pkg::FRAME_AW-1:0]    stop_reg, stop_next;
    logic [bfa_pkg::WORD_AW-1:0]     last_word_reg, last_word_next;
    logic [bfa_pkg::WORD_AW-1:0]     word_reg, word_next;
    logic [bfa_pkg::FRAME_AW-1:0]    cursor_reg, cursor_next;
    logic                            fill_report_reg, fill_report_next;
    logic                            done_reg, done_next;
    bfa_pkg::result_t                result_reg, result_next;

    // Bitmap memory and its ports.
    logic [bfa_pkg::WORD_BITS-1:0]   mem [bfa_pkg::WORDS];
    logic [bfa_pkg::WORD_BITS-1:0]   rd_data_reg;
    logic                            mem_we;
    logic [bfa_pkg::WORD_AW-1:0]     mem_waddr;
    logic [bfa_pkg::WORD_AW-1:0]     mem_raddr;
    logic [bfa_pkg::WORD_BITS-1:0]   mem_wdata;

    // Release region helpers.
    logic [bfa_pkg::END_W-1:0]       stop_raw;
    logic [bfa_pkg::ADDR_W-1:0]      first_raw;
    logic [bfa_pkg::FRAME_AW-1:0]    stop_clip;
    logic [bfa_pkg::FRAME_AW-1:0]    stop_less;
    logic [bfa_pkg::WORD_BITS-1:0]   rel_mask;

    // Allocation scan helpers.
    logic [bfa_pkg::WORD_AW-1:0]     alloc_word;
    logic [bfa_pkg::WORD_BITS-1:0]   free_bits;
    logic [7:0]                      grp_any;
    logic [2:0]                      grp_sel;
    logic [7:0]                      grp_bits;
    logic [2:0]                      bit_sel;
    logic                            alloc_hit;
    logic [bfa_pkg::BIT_AW-1:0]      alloc_idx;
    logic [bfa_pkg::FRAME_AW-1:0]    alloc_frame;
    logic [63:0]                     alloc_bytes;
    logic [bfa_pkg::ADDR_W-1:0]      free_raw;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Region bounds: stop frame rounded up and clipped to the end of memory.
    always_comb
    begin
        stop_raw  = end_reg >> bfa_pkg::FRAME_SHIFT;
        first_raw = cmd_reg.address >> bfa_pkg::FRAME_SHIFT;
        if (stop_raw > bfa_pkg::END_W'(bfa_pkg::NUM_FRAMES))
        begin
            stop_clip = END_FRAME;
        end
        else
        begin
            stop_clip = stop_raw[bfa_pkg::FRAME_AW-1:0];
        end
        stop_less = stop_clip - bfa_pkg::FRAME_AW'(1);
        free_raw  = cmd_reg.address >> bfa_pkg::FRAME_SHIFT;
    end

    // Mask of the bits of the current row that the region covers.
    always_comb
    begin
        logic [bfa_pkg::WORD_BITS-1:0] lo_mask;
        logic [bfa_pkg::WORD_BITS-1:0] hi_mask;
        if (word_reg == first_reg[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW])
        begin
            lo_mask = ONES << first_reg[bfa_pkg::BIT_AW-1:0];
        end
        else
        begin
            lo_mask = ONES;
        end
        if (word_reg == last_word_reg && stop_reg[bfa_pkg::BIT_AW-1:0] != '0)
        begin
            hi_mask = ~(ONES << stop_reg[bfa_pkg::BIT_AW-1:0]);
        end
        else
        begin
            hi_mask = ONES;
        end
        rel_mask = lo_mask & hi_mask;
    end

    // First clear bit at or above the cursor in the row just read.
    always_comb
    begin
        logic [bfa_pkg::WORD_BITS-1:0] masked;
        logic                          g_found;
        logic                          b_found;
        alloc_word = cursor_reg[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW];
        masked = rd_data_reg | ((64'd1 << cursor_reg[bfa_pkg::BIT_AW-1:0]) - 64'd1);
        if (alloc_word == LAST_WORD)
        begin
            masked = masked | bfa_pkg::TAIL_MASK;
        end
        free_bits = ~masked;
        for (int g = 0; g < 8; g++)
        begin
            grp_any[g] = |free_bits[g*8 +: 8];
        end
        g_found = 1'b0;
        grp_sel = '0;
        for (int g = 0; g < 8; g++)
        begin
            if (!g_found && grp_any[g])
            begin
                g_found = 1'b1;
                grp_sel = 3'(g);
            end
        end
        grp_bits = free_bits[grp_sel*8 +: 8];
        b_found = 1'b0;
        bit_sel = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (!b_found && grp_bits[b])
            begin
                b_found = 1'b1;
                bit_sel = 3'(b);
            end
        end
        alloc_hit   = g_found;
        alloc_idx   = {grp_sel, bit_sel};
        alloc_frame = bfa_pkg::FRAME_AW'({alloc_word, alloc_idx});
        alloc_bytes = 64'(alloc_frame) << bfa_pkg::FRAME_SHIFT;
    end

    // Sequencer: next state, memory controls and result.
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        end_next         = end_reg;
        first_next       = first_reg;
        stop_next        = stop_reg;
        last_word_next   = last_word_reg;
        word_next        = word_reg;
        cursor_next      = cursor_reg;
        fill_report_next = fill_report_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        mem_we           = 1'b0;
        mem_waddr        = word_reg;
        mem_wdata        = ONES;
        mem_raddr        = word_reg;

        case (state_reg)
            S_FILL:
            begin
                mem_we = 1'b1;
                if (word_reg == LAST_WORD)
                begin
                    state_next       = S_IDLE;
                    fill_report_next = 1'b0;
                    if (fill_report_reg)
                    begin
                        done_next                 = 1'b1;
                        result_next.frame_address = '0;
                        result_next.status        = bfa_pkg::STATUS_OK;
                    end
                end
                else
                begin
                    word_next = word_reg + bfa_pkg::WORD_AW'(1);
                end
            end

            S_IDLE:
            begin
                mem_raddr = cursor_reg[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW];
                if (start)
                begin
                    cmd_next = command;
                    case (command.func)
                        bfa_pkg::FUNC_MARK_ALL:
                        begin
                            word_next        = '0;
                            fill_report_next = 1'b1;
                            state_next       = S_FILL;
                        end
                        bfa_pkg::FUNC_RELEASE:
                        begin
                            if (command.region_usable)
                            begin
                                state_next = S_REL_SUM;
                            end
                            else
                            begin
                                done_next                 = 1'b1;
                                result_next.frame_address = '0;
                                result_next.status        = bfa_pkg::STATUS_OK;
                            end
                        end
                        bfa_pkg::FUNC_ALLOC:
                        begin
                            if (cursor_reg == END_FRAME)
                            begin
                                done_next                 = 1'b1;
                                result_next.frame_address = '0;
                                result_next.status        = bfa_pkg::STATUS_OOM;
                            end
                            else
                            begin
                                state_next = S_ALLOC_CHK;
                            end
                        end
                        bfa_pkg::FUNC_FREE:
                        begin
                            state_next = S_FREE_CHK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // End of region plus rounding, in bytes.
            S_REL_SUM:
            begin
                end_next = bfa_pkg::END_W'(cmd_reg.address)
                         + bfa_pkg::END_W'(cmd_reg.region_length)
                         + bfa_pkg::END_W'(bfa_pkg::FRAME_BYTES - 1);
                state_next = S_REL_CLIP;
            end

            S_REL_CLIP:
            begin
                if (first_raw >= bfa_pkg::ADDR_W'(stop_clip))
                begin
                    done_next                 = 1'b1;
                    result_next.frame_address = '0;
                    result_next.status        = bfa_pkg::STATUS_OK;
                    state_next                = S_IDLE;
                end
                else
                begin
                    first_next     = first_raw[bfa_pkg::FRAME_AW-1:0];
                    stop_next      = stop_clip;
                    last_word_next = stop_less[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW];
                    word_next      = first_raw[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW];
                    state_next     = S_REL_RD;
                end
            end

            S_REL_RD:
            begin
                state_next = S_REL_WR;
            end

            S_REL_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg & ~rel_mask;
                if (word_reg == last_word_reg)
                begin
                    done_next                 = 1'b1;
                    result_next.frame_address = '0;
                    result_next.status        = bfa_pkg::STATUS_OK;
                    state_next                = S_IDLE;
                end
                else
                begin
                    word_next  = word_reg + bfa_pkg::WORD_AW'(1);
                    state_next = S_REL_RD;
                end
            end

            // One row checked per cycle; the next row is read meanwhile.
            S_ALLOC_CHK:
            begin
                if (alloc_hit)
                begin
                    mem_we                    = 1'b1;
                    mem_waddr                 = alloc_word;
                    mem_wdata                 = rd_data_reg | (64'd1 << alloc_idx);
                    cursor_next               = alloc_frame;
                    done_next                 = 1'b1;
                    result_next.frame_address = alloc_bytes[bfa_pkg::OUT_ADDR_W-1:0];
                    result_next.status        = bfa_pkg::STATUS_OK;
                    state_next                = S_IDLE;
                end
                else if (alloc_word == LAST_WORD)
                begin
                    cursor_next               = END_FRAME;
                    done_next                 = 1'b1;
                    result_next.frame_address = '0;
                    result_next.status        = bfa_pkg::STATUS_OOM;
                    state_next                = S_IDLE;
                end
                else
                begin
                    cursor_next = (bfa_pkg::FRAME_AW'(alloc_word) + bfa_pkg::FRAME_AW'(1))
                                  << bfa_pkg::BIT_AW;
                    mem_raddr   = alloc_word + bfa_pkg::WORD_AW'(1);
                end
            end

            S_FREE_CHK:
            begin
                if (free_raw >= bfa_pkg::ADDR_W'(bfa_pkg::NUM_FRAMES))
                begin
                    done_next                 = 1'b1;
                    result_next.frame_address = '0;
                    result_next.status        = bfa_pkg::STATUS_BADFREE;
                    state_next                = S_IDLE;
                end
                else
                begin
                    first_next = free_raw[bfa_pkg::FRAME_AW-1:0];
                    mem_raddr  = free_raw[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW];
                    state_next = S_FREE_WR;
                end
            end

            S_FREE_WR:
            begin
                done_next                 = 1'b1;
                result_next.frame_address = '0;
                state_next                = S_IDLE;
                if (rd_data_reg[first_reg[bfa_pkg::BIT_AW-1:0]])
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = first_reg[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW];
                    mem_wdata          = rd_data_reg
                                       & ~(64'd1 << first_reg[bfa_pkg::BIT_AW-1:0]);
                    cursor_next        = first_reg;
                    result_next.status = bfa_pkg::STATUS_OK;
                end
                else
                begin
                    result_next.status = bfa_pkg::STATUS_BADFREE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_FILL;
            word_reg        <= '0;
            cursor_reg      <= '0;
            fill_report_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            word_reg        <= word_next;
            cursor_reg      <= cursor_next;
            fill_report_reg <= fill_report_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        end_reg       <= end_next;
        first_reg     <= first_next;
        stop_reg      <= stop_next;
        last_word_reg <= last_word_next;
        result_reg    <= result_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Checks on the sequencer and the cursor.
    `BFA_ASSERT_SAME(a_done_when_idle, done, !busy)
    `BFA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
    `BFA_ASSERT_SAME(a_cursor_bound, 1'b1, cursor_reg <= END_FRAME)
    `BFA_ASSERT_SAME(a_oom_cursor_end, done && result.status == bfa_pkg::STATUS_OOM, cursor_reg == END_FRAME)
    `BFA_ASSERT_SAME(a_error_zero_addr, done && result.status != bfa_pkg::STATUS_OK, result.frame_address == '0)

endmodule
